// ----- rtl/mf_pkg.sv -----
// shared constants, types and codes of the 3x3 median filter
package mf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PRIME_W    = WIDTH_W;

    localparam int WIDTH_RESET  = (1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH;
    localparam int HEIGHT_RESET = (1024 < MAX_HEIGHT) ? 1024 : MAX_HEIGHT;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 8;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    // one classified word handed from the front to the back
    typedef struct packed {
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] pixel;
        logic             emit;
        logic             last;
        logic             top_out;
        logic             bottom_out;
        logic             left_out;
        logic             right_out;
    } work_t;

endpackage

// ----- rtl/mf_front.sv -----
// front end: configuration registers, position counters and word classification
module mf_front import mf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  queue_full,
    output logic                  push,
    output work_t                 work
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    in_col_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [PRIME_W-1:0]  prime_reg;

    logic                accept;
    logic                emit;
    logic                in_col_end;
    logic                out_col_end;
    logic                out_row_end;
    logic                last_word;
    logic [COL_W-1:0]    in_col_next;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        if (v < WIDTH_W'(2))
            return WIDTH_W'(2);
        if (v > WIDTH_W'(MAX_WIDTH))
            return WIDTH_W'(MAX_WIDTH);
        return v;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
        if (v < HEIGHT_W'(2))
            return HEIGHT_W'(2);
        if (v > HEIGHT_W'(MAX_HEIGHT))
            return HEIGHT_W'(MAX_HEIGHT);
        return v;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept;

    assign emit        = !(prime_reg < (WIDTH_W'(prime_reg) ^ prime_reg) + width_reg + WIDTH_W'(1));
    assign in_col_end  = (WIDTH_W'(in_col_reg) + WIDTH_W'(1)) >= width_reg;
    assign out_col_end = (WIDTH_W'(out_col_reg) + WIDTH_W'(1)) >= width_reg;
    assign out_row_end = (HEIGHT_W'(out_row_reg) + HEIGHT_W'(1)) >= height_reg;
    assign last_word   = emit && out_row_end && out_col_end;
    assign in_col_next = in_col_end ? '0 : in_col_reg + COL_W'(1);

    always_comb
    begin
        work.addr       = in_col_reg;
        work.pixel      = (op_t'(operation) == OP_DRAIN) ? '0 : pixel;
        work.emit       = emit;
        work.last       = last_word;
        work.top_out    = (out_row_reg == '0);
        work.bottom_out = out_row_end;
        work.left_out   = (out_col_reg == '0);
        work.right_out  = out_col_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_W'(WIDTH_RESET);
            height_reg  <= HEIGHT_W'(HEIGHT_RESET);
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            prime_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= clamp_width(cfg_data[WIDTH_W-1:0]);
                REG_IMAGE_HEIGHT: height_reg <= clamp_height(cfg_data[HEIGHT_W-1:0]);
                default:          ;
            endcase
            in_col_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            prime_reg   <= '0;
        end
        else if (accept)
        begin
            in_col_reg <= last_word ? '0 : in_col_next;
            if (!emit)
                prime_reg <= prime_reg + PRIME_W'(1);
            else if (last_word)
            begin
                prime_reg   <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (out_col_end)
            begin
                out_col_reg <= '0;
                out_row_reg <= out_row_reg + ROW_W'(1);
            end
            else
                out_col_reg <= out_col_reg + COL_W'(1);
        end
    end

endmodule

// ----- rtl/mf_queue.sv -----
// short queue of classified words between front and back
module mf_queue import mf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t push_data,
    input  logic  pop,
    output work_t head,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t              store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- rtl/mf_back.sv -----
// back end: line stores, 3x3 window, pipelined median network and result fifo
module mf_back import mf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             queue_empty,
    input  work_t            head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] median,
    output logic             last
);

    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] hi;
    } trio_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } result_t;

    // line stores
    logic [PIX_W-1:0] near_mem [MAX_WIDTH];
    logic [PIX_W-1:0] far_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] near_rd_reg;
    logic [PIX_W-1:0] far_rd_reg;

    // pipeline
    logic             s1_valid_reg;
    work_t            s1_reg;
    logic [PIX_W-1:0] win_reg [3][3];
    logic             s2_valid_reg;
    logic             s2_last_reg;
    logic             s2_top_reg;
    logic             s2_bottom_reg;
    logic             s2_left_reg;
    logic             s2_right_reg;
    logic [PIX_W-1:0] padded [3][3];
    trio_t            s3_rows_reg [3];
    logic             s3_valid_reg;
    logic             s3_last_reg;
    trio_t            lo_set;
    trio_t            mid_set;
    trio_t            hi_set;
    trio_t            s4_reg;
    logic             s4_valid_reg;
    logic             s4_last_reg;
    trio_t            final_set;

    // result fifo
    result_t           out_mem_reg [OUT_DEPTH];
    logic [OPTR_W-1:0] out_wr_reg;
    logic [OPTR_W-1:0] out_rd_reg;
    logic [OCNT_W-1:0] out_cnt_reg;
    logic [OCNT_W-1:0] reserved_reg;
    logic              out_take;
    logic              out_push;

    function automatic trio_t sort3(input logic [PIX_W-1:0] a,
                                    input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] lo_ab;
        logic [PIX_W-1:0] hi_ab;
        trio_t            t;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a < b) ? b : a;
        t.lo  = (lo_ab < c) ? lo_ab : c;
        t.hi  = (hi_ab < c) ? c : hi_ab;
        if (c < lo_ab)
            t.mid = lo_ab;
        else if (c > hi_ab)
            t.mid = hi_ab;
        else
            t.mid = c;
        return t;
    endfunction

    // a result slot is reserved when a word that yields a result leaves the queue
    assign pop      = !queue_empty && (reserved_reg < OCNT_W'(OUT_DEPTH));
    assign out_take = out_valid && out_ready;
    assign out_push = s4_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            near_rd_reg         <= near_mem[head.addr];
            near_mem[head.addr] <= head.pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (s1_valid_reg && (s1_reg.addr == head.addr))
                far_rd_reg <= near_rd_reg;
            else
                far_rd_reg <= far_mem[head.addr];
        end
        if (s1_valid_reg)
            far_mem[s1_reg.addr] <= near_rd_reg;
    end

    // window shift and pad values for neighbours outside the image:
    // the pads are split into zeros and full-scale values so that the
    // centre of all nine gives the upper median of the pixels inside
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic row_out;
                logic col_out;
                logic first_row;
                row_out   = (r == 0 && s2_top_reg) || (r == 2 && s2_bottom_reg);
                col_out   = (c == 0 && s2_left_reg) || (c == 2 && s2_right_reg);
                first_row = s2_top_reg ? (r == 1) : (r == 0);
                if (!row_out && !col_out)
                    padded[r][c] = win_reg[r][c];
                else if ((row_out && c == 0) || (!row_out && first_row))
                    padded[r][c] = '0;
                else
                    padded[r][c] = PIX_MAX;
            end
        end
    end

    // column sorts across the sorted rows, then the last three-way median
    assign lo_set    = sort3(s3_rows_reg[0].lo, s3_rows_reg[1].lo, s3_rows_reg[2].lo);
    assign mid_set   = sort3(s3_rows_reg[0].mid, s3_rows_reg[1].mid, s3_rows_reg[2].mid);
    assign hi_set    = sort3(s3_rows_reg[0].hi, s3_rows_reg[1].hi, s3_rows_reg[2].hi);
    assign final_set = sort3(s4_reg.lo, s4_reg.mid, s4_reg.hi);

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_reg <= head;
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= far_rd_reg;
            win_reg[1][2] <= near_rd_reg;
            win_reg[2][2] <= s1_reg.pixel;
            s2_last_reg   <= s1_reg.last;
            s2_top_reg    <= s1_reg.top_out;
            s2_bottom_reg <= s1_reg.bottom_out;
            s2_left_reg   <= s1_reg.left_out;
            s2_right_reg  <= s1_reg.right_out;
        end
        for (int r = 0; r < 3; r++)
            s3_rows_reg[r] <= sort3(padded[r][0], padded[r][1], padded[r][2]);
        s3_last_reg <= s2_last_reg;
        s4_reg.lo   <= lo_set.hi;
        s4_reg.mid  <= mid_set.mid;
        s4_reg.hi   <= hi_set.lo;
        s4_last_reg <= s3_last_reg;
        if (out_push)
        begin
            out_mem_reg[out_wr_reg].value <= final_set.mid;
            out_mem_reg[out_wr_reg].last  <= s4_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            out_wr_reg   <= '0;
            out_rd_reg   <= '0;
            out_cnt_reg  <= '0;
            reserved_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg && s1_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (out_push)
                out_wr_reg <= out_wr_reg + OPTR_W'(1);
            if (out_take)
                out_rd_reg <= out_rd_reg + OPTR_W'(1);
            if (out_push && !out_take)
                out_cnt_reg <= out_cnt_reg + OCNT_W'(1);
            else if (out_take && !out_push)
                out_cnt_reg <= out_cnt_reg - OCNT_W'(1);
            if ((pop && head.emit) && !out_take)
                reserved_reg <= reserved_reg + OCNT_W'(1);
            else if (out_take && !(pop && head.emit))
                reserved_reg <= reserved_reg - OCNT_W'(1);
        end
    end

    assign out_valid = (out_cnt_reg != '0);
    assign median    = out_mem_reg[out_rd_reg].value;
    assign last      = out_mem_reg[out_rd_reg].last;

endmodule

// ----- rtl/median_filter_3x3_core.sv -----
// top level of the streaming 3x3 median filter
//
// streaming 3x3 median filter for 8-bit grayscale pixels in raster order.
// the block takes one input word per clock and gives one result word per
// clock, sustained, while the output side keeps taking them. each result is
// the median of the neighbours of one pixel that lie inside the image (four
// at corners, six on edges, nine inside), the upper median for an even
// count. a result belongs to the input word accepted image_width+1 words
// earlier: the first image_width+1 words of an image give nothing, and after
// the last pixel the source sends image_width+1 drain words to flush the
// tail; the final result carries last. from leaving the internal queue to
// reaching the output a word passes the line store read, the window shift,
// the row sorts, the column sorts and the result fifo.
// the two line stores are single memories of 1024 x 8, read once and
// written once per word. they are not cleared after reset, and no clearing
// pass runs: rows above the image are never used. a register write restarts
// the image and must only be issued while the block is idle.
module median_filter_3x3_core import mf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  operation,
    input  logic [PIX_W-1:0]      pixel,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      median,
    output logic                  last
);

    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;
    work_t push_word;
    work_t head_word;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // front: counts positions, decides whether a word yields a result and
    // where its window crosses the image border
    mf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .pixel      (pixel),
        .queue_full (queue_full),
        .push       (push),
        .work       (push_word)
    );

    // decouples the input side from back-pressure on the result side
    mf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_word),
        .pop       (pop),
        .head      (head_word),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back: line stores, window and median network, results into a fifo
    mf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head_word),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .median      (median),
        .last        (last)
    );

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the streaming 3x3 median filter core
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mf_pkg::*;

    // pause before a register write, covers the internal queue and the pipe
    localparam int SETTLE_CYCLES = 32;
    // random words after the directed part
    localparam int RANDOM_WORDS  = 720;
    // cycles allowed for the tail of the run to come out
    localparam int DRAIN_LIMIT   = 200000;

    // one input word as queued for the driver
    typedef struct {
        op_t              op;
        logic [PIX_W-1:0] value;
    } pixel_word_t;

    // one filtered pixel as the block should give it
    typedef struct {
        logic [PIX_W-1:0] median;
        logic             last;
    } filtered_t;

    // shape of one image in the stimulus
    typedef enum {
        IMG_CLEAN,  // all pixels, then exactly width+1 drain words
        IMG_NOISY,  // drain words inside the image, pixels in the flush
        IMG_CUT     // stops part way, the next phase restarts the image
    } image_kind_t;

    // receiver behaviour
    typedef enum {
        RX_OPEN,     // always ready
        RX_CHOPPY,   // ready three times in four
        RX_STALLING  // runs of stall cycles
    } rx_mode_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [0:0]            cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  operation = OP_PIXEL;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      median;
    logic                  last;

    median_filter_3x3_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .median    (median),
        .last      (last)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // filter prediction: own copy of line stores, window and counters
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] near_mem [MAX_WIDTH];  // row just above
    logic [PIX_W-1:0] far_mem  [MAX_WIDTH];  // two rows above
    logic [PIX_W-1:0] win      [3][3];       // sliding window, column 2 newest
    logic [PIX_W-1:0] prev_win [3][3];       // window before this word's shift
    logic [PIX_W-1:0] held     [3][3];       // window of the pixel now due out
    logic [PIX_W-1:0] sorted   [9];

    int img_w = WIDTH_RESET;
    int img_h = HEIGHT_RESET;
    int in_col = 0;
    int out_col = 0;
    int out_row = 0;
    int primed = 0;

    filtered_t   filtered_q [$];  // filtered pixels not yet seen on the output
    pixel_word_t pending_q  [$];  // words waiting for the driver
    int          words_in_flight = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          words_queued = 0;

    function automatic void restart_image();
        in_col  = 0;
        out_col = 0;
        out_row = 0;
        primed  = 0;
    endfunction

    // register write: clamp to the legal range, then start a fresh image
    function automatic void apply_reg(input reg_index_t idx,
                                      input logic [CFG_DATA_W-1:0] data);
        int v;
        if (idx == REG_IMAGE_WIDTH) begin
            v = data[WIDTH_W-1:0];
            img_w = (v < 2) ? 2 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
        end else begin
            v = data[HEIGHT_W-1:0];
            img_h = (v < 2) ? 2 : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
        end
        restart_image();
    endfunction

    // one accepted word: shift it through the line stores and the window,
    // and once primed queue the median of the pixel that falls due
    function automatic void advance_filter(input op_t op, input logic [PIX_W-1:0] value);
        logic [PIX_W-1:0] p;
        logic [PIX_W-1:0] vfar;
        logic [PIX_W-1:0] vnear;
        logic [PIX_W-1:0] v;
        int c, r, k, j, n, rr, cc;
        filtered_t res;

        // a drain word counts as a black pixel
        p = (op == OP_DRAIN) ? '0 : value;
        c = in_col;

        vfar  = far_mem[c];
        vnear = near_mem[c];
        far_mem[c]  = vnear;
        near_mem[c] = p;

        for (r = 0; r < 3; r++) begin
            for (k = 0; k < 3; k++)
                prev_win[r][k] = win[r][k];
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = vfar;
        win[1][2] = vnear;
        win[2][2] = p;

        // at column 0 the pixel due out ends the row before: its window is
        // the old one moved left with nothing on the right
        for (r = 0; r < 3; r++) begin
            if (c == 0) begin
                held[r][0] = prev_win[r][1];
                held[r][1] = prev_win[r][2];
                held[r][2] = '0;
            end else begin
                for (k = 0; k < 3; k++)
                    held[r][k] = win[r][k];
            end
        end

        in_col = (c + 1 >= img_w) ? 0 : c + 1;

        if (primed < img_w + 1) begin
            primed++;
            return;
        end

        // insertion sort of the neighbours inside the image
        n = 0;
        for (r = 0; r < 3; r++) begin
            rr = out_row + r - 1;
            if (rr >= 0 && rr < img_h) begin
                for (k = 0; k < 3; k++) begin
                    cc = out_col + k - 1;
                    if (cc >= 0 && cc < img_w) begin
                        v = held[r][k];
                        j = n;
                        while (j > 0 && sorted[j-1] > v) begin
                            sorted[j] = sorted[j-1];
                            j--;
                        end
                        sorted[j] = v;
                        n++;
                    end
                end
            end
        end

        res.median = sorted[n/2];  // upper median for four or six neighbours
        res.last   = (out_row + 1 >= img_h) && (out_col + 1 >= img_w);
        filtered_q.insert(filtered_q.size(), res);

        if (res.last)
            restart_image();
        else if (out_col + 1 >= img_w) begin
            out_col = 0;
            out_row++;
        end else
            out_col++;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps, fed by pending_q
    // ------------------------------------------------------------------
    int          burst_left;
    int          gap_left;
    pixel_word_t next_word;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            // prediction runs on the word as it is taken
            if (in_valid && in_ready) begin
                advance_filter(op_t'(operation), pixel);
                words_in_flight--;
            end
            // the valid may only change once the current word has gone
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_q.size() != 0) begin
                    next_word = pending_q[0];
                    pending_q.delete(0);
                    in_valid  <= 1'b1;
                    operation <= next_word.op;
                    pixel     <= next_word.value;
                    if (burst_left > 1)
                        burst_left--;
                    else if ($urandom_range(0, 7) == 0) begin
                        // a long stretch with no gaps at all
                        burst_left = 300;
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                               : $urandom_range(1, 6);
                    end
                end else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each word taken and stalls on a pattern of its own
    // ------------------------------------------------------------------
    rx_mode_t  rx_mode;
    int        rx_mode_left;
    int        rx_stall_left;
    filtered_t want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_mode = RX_OPEN;
            rx_mode_left = 0;
            rx_stall_left = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (filtered_q.size() == 0)
                    flag_mismatch($sformatf("median %0d last %0b with nothing expected",
                                            median, last));
                else begin
                    want = filtered_q[0];
                    filtered_q.delete(0);
                    if (median !== want.median)
                        flag_mismatch($sformatf("word %0d: median %0d, expected %0d",
                                                results_seen, median, want.median));
                    if (last !== want.last)
                        flag_mismatch($sformatf("word %0d: last %0b, expected %0b",
                                                results_seen, last, want.last));
                end
                results_seen++;
            end

            if (rx_mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(20, 150);
            end else
                rx_mode_left--;

            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_CHOPPY: out_ready <= ($urandom_range(0, 3) != 0);
                default: begin
                    if (rx_stall_left > 0) begin
                        rx_stall_left--;
                        out_ready <= 1'b0;
                    end else begin
                        out_ready <= 1'b1;
                        if ($urandom_range(0, 2) == 0)
                            rx_stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic void push_word(input op_t op, input logic [PIX_W-1:0] value);
        pixel_word_t w;
        w.op = op;
        w.value = value;
        pending_q.insert(pending_q.size(), w);
        words_in_flight++;
        words_queued++;
    endfunction

    // wait until every queued word is taken and every filtered pixel is out
    task automatic hold_until_flushed();
        while (words_in_flight != 0 || filtered_q.size() != 0)
            @(posedge clk);
    endtask

    // idle block: nothing pending, plus time for priming words still inside
    task automatic settle();
        hold_until_flushed();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    // one image at the current size, random pixel values
    task automatic queue_image(input image_kind_t kind, input bit pause_midway);
        int npix, total, k;
        op_t op;
        npix  = img_w * img_h;
        total = npix + img_w + 1;
        if (kind == IMG_CUT)
            total = $urandom_range(1, total - 1);
        for (k = 0; k < total; k++) begin
            if (k < npix)
                op = (kind == IMG_NOISY && $urandom_range(0, 9) == 0) ? OP_DRAIN : OP_PIXEL;
            else
                op = (kind == IMG_NOISY && $urandom_range(0, 2) == 0) ? OP_PIXEL : OP_DRAIN;
            push_word(op, $urandom_range(0, 255));
            if (pause_midway && k == npix / 2)
                hold_until_flushed();
        end
    endtask

    // a fixed number of random pixels, the image left unfinished
    task automatic queue_words(input int count);
        int k;
        for (k = 0; k < count; k++)
            push_word(OP_PIXEL, $urandom_range(0, 255));
    endtask

    initial begin
        int w, h, wd, hd, which, nimg, i, base, pick;
        image_kind_t kind;
        bit first_phase;
        int guard;

        for (i = 0; i < MAX_WIDTH; i++) begin
            near_mem[i] = '0;
            far_mem[i] = '0;
        end
        for (i = 0; i < 9; i++)
            win[i/3][i%3] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset: 1024 wide, so these words only prime
        push_word(OP_PIXEL, 8'hFF);
        push_word(OP_DRAIN, 8'h00);
        push_word(OP_PIXEL, 8'h00);
        push_word(OP_DRAIN, 8'hFF);

        // 3x3 image: corners, edges and the centre all come out once
        write_reg(REG_IMAGE_WIDTH, 13'd3);
        write_reg(REG_IMAGE_HEIGHT, 13'd3);
        push_word(OP_PIXEL, 8'd255);
        push_word(OP_PIXEL, 8'd0);
        push_word(OP_PIXEL, 8'd128);
        push_word(OP_PIXEL, 8'd1);
        push_word(OP_DRAIN, 8'hA5);   // drain word inside the image reads as black
        push_word(OP_PIXEL, 8'd254);
        push_word(OP_PIXEL, 8'd127);
        // sender holds until all that is due has come out
        hold_until_flushed();
        push_word(OP_PIXEL, 8'h55);
        push_word(OP_PIXEL, 8'hAA);
        push_word(OP_DRAIN, 8'h00);
        push_word(OP_PIXEL, 8'hFF);   // pixel past the image end acts as a drain
        push_word(OP_DRAIN, 8'h00);
        push_word(OP_DRAIN, 8'h00);

        // smallest image, both sizes written below range and clamped up;
        // the width write carries junk above the 11-bit field
        write_reg(REG_IMAGE_WIDTH, 13'h1001);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        queue_image(IMG_CLEAN, 1'b0);

        // widest rows, width written above range: too few words to prime
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        queue_words(40);

        // tallest image, narrowest rows, left well short of its end
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
        queue_words(60);

        // random phases: mostly small well-formed images with random pixels,
        // some noisy and some cut short
        base = words_queued;
        first_phase = 1'b1;
        while (words_queued - base < RANDOM_WORDS) begin
            pick = $urandom_range(0, 19);
            w = (pick < 14) ? $urandom_range(2, 6) :
                (pick < 19) ? $urandom_range(7, 20) : $urandom_range(21, 64);
            if (w > 20)
                h = $urandom_range(2, 4);
            else
                h = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 6) : $urandom_range(7, 16);
            wd = (w == 2 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : w;
            wd = wd | ($urandom_range(0, 3) << WIDTH_W);
            hd = (h == 2 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : h;

            which = first_phase ? 3 : $urandom_range(0, 3);
            first_phase = 1'b0;
            if (which == 0)
                write_reg(REG_IMAGE_WIDTH, wd);
            else if (which == 1)
                write_reg(REG_IMAGE_HEIGHT, hd);
            else if (which == 2) begin
                write_reg(REG_IMAGE_WIDTH, wd);
                write_reg(REG_IMAGE_HEIGHT, hd);
            end else begin
                write_reg(REG_IMAGE_HEIGHT, hd);
                write_reg(REG_IMAGE_WIDTH, wd);
            end

            nimg = $urandom_range(1, 3);
            for (i = 0; i < nimg; i++) begin
                pick = $urandom_range(0, 9);
                kind = (pick < 7) ? IMG_CLEAN : (pick < 9) ? IMG_NOISY : IMG_CUT;
                queue_image(kind, $urandom_range(0, 11) == 0);
                if (kind == IMG_CUT)
                    break;
            end
        end

        // let everything come out, then give the pipe time to show extras
        guard = 0;
        while ((words_in_flight != 0 || filtered_q.size() != 0) && guard < DRAIN_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (filtered_q.size() != 0)
            flag_mismatch($sformatf("%0d filtered pixels never came out", filtered_q.size()));

        if (mismatches == 0)
            $display("[median_filter_3x3_core] OK");
        else
            $display("[median_filter_3x3_core] ERROR");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #20_000_000;
        $display("[median_filter_3x3_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mf_pkg.sv
rtl/mf_front.sv
rtl/mf_queue.sv
rtl/mf_back.sv
rtl/median_filter_3x3_core.sv
bench/testbench.sv
